### rtl/kmv_pkg.sv
// Shared constants, codes and the token type of the k-minimum-values sketch.
// Used by kmv_cell, kmv_div and kmv_distinct_count_sketch; depends on nothing.
package kmv_pkg;

    localparam int K_MAX  = 64;
    localparam int IDX_W  = $clog2(K_MAX);
    localparam int K_W    = IDX_W + 1;
    localparam int HASH_W = 32;
    localparam int EST_W  = 32;
    localparam int OP_W   = 2;
    localparam int KIND_W = 2;

    // request operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // token kinds travelling down the cell chain
    localparam logic [KIND_W-1:0] TOK_SEARCH = 2'd0;
    localparam logic [KIND_W-1:0] TOK_SHIFT  = 2'd1;
    localparam logic [KIND_W-1:0] TOK_QUERY  = 2'd2;
    localparam logic [KIND_W-1:0] TOK_CLEAR  = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [K_W-1:0]    k;
        logic [HASH_W-1:0] data;
    } token_t;

endpackage

### rtl/kmv_distinct_count_sketch.sv
// Top level of the k-minimum-values distinct-count sketch: cell chain and divider.
// Depends on kmv_pkg, kmv_cell and kmv_div.
//
//   channel | signals                            | direction | payload
//   --------+------------------------------------+-----------+---------------------------
//   input   | in_valid, in_stall                 | in        | operation, key_hash
//   output  | out_valid, out_stall               | out       | estimate
//   config  | cfg_we, cfg_wdata                  | in        | k_in_use (7 bits)
//
// One request is taken per cycle while in_stall is low. Each request becomes a
// token that walks the 64-cell chain one cell per cycle while the chain is not held,
// and then a query takes the divider: saturated, or a 32-step bit-serial divide.
// The chain halts, and in_stall rises, only while a query token sits at the end
// of the chain and the divider still holds or works on an earlier query.
// Reset is asynchronous: every list entry goes to all ones and k_in_use to 64.
module kmv_distinct_count_sketch (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [kmv_pkg::OP_W-1:0]   operation,
    input  logic [kmv_pkg::HASH_W-1:0] key_hash,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [kmv_pkg::EST_W-1:0]  estimate,
    input  logic                       cfg_we,
    input  logic [kmv_pkg::K_W-1:0]    cfg_wdata
);
    import kmv_pkg::*;

    logic [K_W-1:0] k_in_use_reg;
    logic [K_W-1:0] eff_k;
    token_t         chain [0:K_MAX];
    token_t         head;
    token_t         tail;
    logic           adv;
    logic           div_ready;
    logic           div_start;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_in_use_reg <= K_W'(K_MAX);
        end
        else if (cfg_we)
        begin
            k_in_use_reg <= cfg_wdata;
        end
    end

    // clamp k: zero acts as one, anything above the chain length as the length
    always_comb
    begin
        if (k_in_use_reg == '0)
        begin
            eff_k = K_W'(1);
        end
        else if (k_in_use_reg > K_W'(K_MAX))
        begin
            eff_k = K_W'(K_MAX);
        end
        else
        begin
            eff_k = k_in_use_reg;
        end
    end

    // build the head token; each token carries its own k down the chain
    always_comb
    begin
        head.valid = 1'b0;
        head.kind  = TOK_SEARCH;
        head.k     = eff_k;
        head.data  = key_hash;
        unique case (operation)
            OP_INSERT:
            begin
                head.valid = in_valid;
                head.kind  = TOK_SEARCH;
            end
            OP_QUERY:
            begin
                head.valid = in_valid;
                head.kind  = TOK_QUERY;
            end
            OP_CLEAR:
            begin
                head.valid = in_valid;
                head.kind  = TOK_CLEAR;
            end
            default:
            begin
                // unknown operation: drop the request
                head.valid = 1'b0;
            end
        endcase
    end

    assign chain[0] = head;
    assign tail     = chain[K_MAX];

    // hold the whole chain while a query at its end waits for the divider
    assign adv       = !(tail.valid && tail.kind == TOK_QUERY && !div_ready);
    assign div_start = adv && tail.valid && tail.kind == TOK_QUERY;
    assign in_stall  = !adv;

    for (genvar j = 0; j < K_MAX; j++)
    begin : g_cell
        kmv_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .idx     (IDX_W'(j)),
            .tok_in  (chain[j]),
            .tok_out (chain[j+1])
        );
    end

    // the query token brings the k-th entry in its data field
    kmv_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .k         (tail.k),
        .divisor   (tail.data),
        .ready     (div_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .quotient  (estimate)
    );

endmodule

### rtl/kmv_cell.sv
// One cell of the sorted minimum-hash chain: holds one list entry and one token.
// Depends on kmv_pkg.
module kmv_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic [kmv_pkg::IDX_W-1:0] idx,
    input  kmv_pkg::token_t       tok_in,
    output kmv_pkg::token_t       tok_out
);
    import kmv_pkg::*;

    logic [HASH_W-1:0] val_reg;
    logic [HASH_W-1:0] val_next;
    token_t            tok_reg;
    token_t            tok_next;
    logic              active;
    logic              last;

    assign active = tok_in.k > K_W'(idx);
    assign last   = tok_in.k == (K_W'(idx) + K_W'(1));

    always_comb
    begin
        val_next = val_reg;
        tok_next = tok_in;
        if (tok_in.valid)
        begin
            case (tok_in.kind)
                TOK_SEARCH:
                begin
                    if (!active || val_reg == tok_in.data)
                    begin
                        // beyond the list or already present: drop
                        tok_next.valid = 1'b0;
                    end
                    else if (val_reg > tok_in.data)
                    begin
                        val_next      = tok_in.data;
                        tok_next.kind = TOK_SHIFT;
                        tok_next.data = val_reg;
                    end
                end
                TOK_SHIFT:
                begin
                    if (!active)
                    begin
                        tok_next.valid = 1'b0;
                    end
                    else
                    begin
                        val_next      = tok_in.data;
                        tok_next.data = val_reg;
                    end
                end
                TOK_QUERY:
                begin
                    if (last)
                    begin
                        tok_next.data = val_reg;
                    end
                end
                TOK_CLEAR:
                begin
                    val_next = '1;
                end
                default:
                begin
                    tok_next.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg       <= '1;
            tok_reg.valid <= 1'b0;
            tok_reg.kind  <= TOK_SEARCH;
            tok_reg.k     <= '0;
            tok_reg.data  <= '0;
        end
        else if (adv)
        begin
            val_reg <= val_next;
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

### rtl/kmv_div.sv
// Bit-serial divider for the estimate floor(k*(2^32-1)/d), saturated to 32 bits.
// Holds the result until the output request is taken. Depends on kmv_pkg.
module kmv_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [kmv_pkg::K_W-1:0]    k,
    input  logic [kmv_pkg::HASH_W-1:0] divisor,
    output logic                   ready,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [kmv_pkg::EST_W-1:0]  quotient
);
    import kmv_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam int CNT_W = $clog2(EST_W);

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [HASH_W-1:0] rem_reg;
    logic [HASH_W-1:0] rem_next;
    logic [HASH_W-1:0] div_reg;
    logic [HASH_W-1:0] div_next;
    logic [EST_W-1:0]  quo_reg;
    logic [EST_W-1:0]  quo_next;

    logic [HASH_W-1:0] k_hi;
    logic              sat;
    logic [HASH_W:0]   trial;
    logic              fits;

    // dividend = k*2^32 - k: upper part k-1, lower part -k
    assign k_hi  = HASH_W'(k) - HASH_W'(1);
    assign sat   = k_hi >= divisor;
    assign trial = {rem_reg, quo_reg[EST_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        quo_next   = quo_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    div_next = divisor;
                    cnt_next = '1;
                    rem_next = k_hi;
                    if (sat)
                    begin
                        // quotient beyond 32 bits or zero divisor
                        quo_next   = '1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // low dividend bits shift out as quotient bits shift in
                        quo_next   = EST_W'(HASH_W'(0) - HASH_W'(k));
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                rem_next = fits ? HASH_W'(trial - {1'b0, div_reg}) : trial[HASH_W-1:0];
                quo_next = {quo_reg[EST_W-2:0], fits};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign ready     = state_reg == ST_IDLE;
    assign out_valid = state_reg == ST_DONE;
    assign quotient  = quo_reg;

endmodule
